@@ rtl/core/set_assoc_cache_tag_lookup_unit_assert.svh @@
// Assertion macros for the cache tag lookup block.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH
// Consequent checked in the same cycle as the antecedent.
`define SACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/sacl_pkg.sv @@
// Shared types and constants for the cache tag lookup block.
// No dependencies.
package sacl_pkg;

  // Way numbers carried between modules are sized for the largest way count.
  localparam int WAY_IDX_W = 4;

  // Block offset register: width, reset value and the legal range.
  localparam int OFS_W = 4;
  localparam logic [OFS_W-1:0] OFS_RESET = 4'd6;
  localparam logic [OFS_W-1:0] OFS_MIN   = 4'd2;
  localparam logic [OFS_W-1:0] OFS_MAX   = 4'd12;

  // Lookup decision for one set.
  typedef struct packed {
    logic                 hit;    // a valid way matched
    logic                 flush;  // miss with every way valid
    logic [WAY_IDX_W-1:0] way;    // hit way, or way to fill
  } lookup_res_t;

endpackage

@@ rtl/core/set_assoc_cache_tag_lookup_unit.sv @@
// Set-associative cache tag lookup: top level. Depends on sacl_pkg, sacl_way_match.
// Result registered on leaving LOOK (read the set row, then update it); a stalled
// output holds LOOK. No new request is taken until the read-modify-write of the
// set row is done. Reset (rst, sync): counters zero, offset 6, then a pass clears
// the valid bits row by row; no input transfer is taken during that pass.
// SET_COUNT is a power of two; set = low block-address bits, tag = the rest.
`include "set_assoc_cache_tag_lookup_unit_assert.svh"

module set_assoc_cache_tag_lookup_unit #(
  parameter int SET_COUNT = 128,
  parameter int NUM_WAYS  = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration: block offset bits
  input  logic                       cfg_wr_en,
  input  logic [sacl_pkg::OFS_W-1:0] cfg_wr_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ADDR_BITS-1:0]       address,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic [1:0]                 way,
  output logic                       set_flushed,
  output logic [6:0]                 set_index,
  output logic [31:0]                hit_total,
  output logic [31:0]                miss_total,
  output logic [31:0]                access_total
);

  // Geometry. SET_LOG is zero for a single set; index widths stay at least 1.
  localparam int SET_LOG = $clog2(SET_COUNT);
  localparam int SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  // Smallest block offset is 2, so the tag keeps every bit above the set field.
  localparam int TAG_W   = ADDR_BITS - 2 - SET_LOG;
  // One memory row per set: valid bits on top, then the tags, way 0 lowest.
  localparam int ROW_W   = NUM_WAYS * (TAG_W + 1);
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SET_COUNT - 1);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,   // post-reset valid clear sweep
    ST_IDLE  = 3'b010,   // ready for a request
    ST_LOOK  = 3'b100    // row data available, decide and write back
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [SET_W-1:0]           clr_cnt;
  logic [sacl_pkg::OFS_W-1:0] ofs_reg;
  logic [sacl_pkg::OFS_W-1:0] ofs_eff;

  logic [ADDR_BITS-1:0]       line_addr;
  logic [ADDR_BITS-1:0]       tag_full;
  logic [SET_W-1:0]           set_in;
  logic [SET_W-1:0]           set_q;
  logic [TAG_W-1:0]           tag_q;

  logic [ROW_W-1:0]           mem [SET_COUNT];
  logic [ROW_W-1:0]           rd_row;
  logic                       mem_we;
  logic [SET_W-1:0]           mem_waddr;
  logic [ROW_W-1:0]           mem_wdata;

  logic [NUM_WAYS-1:0]        row_valid;
  logic [NUM_WAYS*TAG_W-1:0]  row_tags;
  logic [NUM_WAYS-1:0]        new_valid;
  logic [NUM_WAYS*TAG_W-1:0]  new_tags;
  sacl_pkg::lookup_res_t      res;

  logic                       in_xfer;
  logic                       out_free;
  logic                       done;

  // ---------------------------------------------------------------------------
  // Handshake. A request is taken only in IDLE; the result register is free
  // when empty or when its current result transfers this cycle.
  // ---------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign done     = (state == ST_LOOK) && out_free;

  // ---------------------------------------------------------------------------
  // Address split. Offset is clamped to 2..12 before the shift.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (ofs_reg < sacl_pkg::OFS_MIN) begin
      ofs_eff = sacl_pkg::OFS_MIN;
    end else if (ofs_reg > sacl_pkg::OFS_MAX) begin
      ofs_eff = sacl_pkg::OFS_MAX;
    end else begin
      ofs_eff = ofs_reg;
    end
  end

  assign line_addr = address >> ofs_eff;
  assign tag_full  = line_addr >> SET_LOG;
  assign set_in    = line_addr[SET_W-1:0] & SET_MASK;

  // ---------------------------------------------------------------------------
  // Set row memory: one write port, one registered read port. The read is
  // issued on the request transfer; the write-back lands when leaving LOOK,
  // before the next request can read, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_row <= mem[set_in];
    end
  end

  assign row_valid = rd_row[ROW_W-1 -: NUM_WAYS];
  assign row_tags  = rd_row[NUM_WAYS*TAG_W-1:0];

  sacl_way_match #(
    .NUM_WAYS (NUM_WAYS),
    .TAG_W    (TAG_W)
  ) u_match (
    .row_valid (row_valid),
    .row_tags  (row_tags),
    .tag       (tag_q),
    .res       (res)
  );

  // Updated row for a miss: fill the chosen way, or on a flush keep only way 0.
  always_comb begin
    new_valid = row_valid;
    new_tags  = row_tags;
    if (res.flush) begin
      new_valid              = '0;
      new_valid[0]           = 1'b1;
      new_tags[0 +: TAG_W]   = tag_q;
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (res.way[WAY_W-1:0] == WAY_W'(w)) begin
          new_valid[w]              = 1'b1;
          new_tags[w*TAG_W +: TAG_W] = tag_q;
        end
      end
    end
  end

  // Write mux: clear sweep zeroes whole rows; a miss writes back the set.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = {new_valid, new_tags};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_LOOK: begin
        mem_we = done && !res.hit;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control sequence
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      ofs_reg <= sacl_pkg::OFS_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_wr_en) begin
        ofs_reg <= cfg_wr_data;
      end
    end
  end

  // Request fields held for the LOOK cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      set_q <= set_in;
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register and counters. Counters only move when a new result is
  // loaded, so they double as the stable total fields of the result.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      hit_total    <= '0;
      miss_total   <= '0;
      access_total <= '0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
        if (access_total != '1) begin
          access_total <= access_total + 32'd1;
        end
        if (res.hit && (hit_total != '1)) begin
          hit_total <= hit_total + 32'd1;
        end
        if (!res.hit && (miss_total != '1)) begin
          miss_total <= miss_total + 32'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit         <= res.hit;
      way         <= 2'(res.way);
      set_flushed <= res.flush;
      set_index   <= 7'(set_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SACL_ASSERT_NEXT(a_xfer_to_look, clk, rst, in_xfer, state == ST_LOOK,
    "request transfer did not move to LOOK")
  `SACL_ASSERT_NOW(a_no_take_in_clear, clk, rst, state == ST_CLEAR, in_stall,
    "request taken during clear sweep")
  `SACL_ASSERT_NOW(a_hit_no_flush, clk, rst, out_valid, !(hit && set_flushed),
    "hit reported with set flush")
  `SACL_ASSERT_NOW(a_count_sum, clk, rst, access_total != '1,
    ({1'b0, hit_total} + {1'b0, miss_total}) == {1'b0, access_total},
    "hit plus miss count differs from access count")

endmodule

@@ rtl/core/sacl_way_match.sv @@
// Tag compare and replacement pick for one set row.
// Depends on sacl_pkg (lookup_res_t, WAY_IDX_W).
module sacl_way_match #(
  parameter int NUM_WAYS = 4,
  parameter int TAG_W    = 23
) (
  input  logic [NUM_WAYS-1:0]       row_valid,
  input  logic [NUM_WAYS*TAG_W-1:0] row_tags,
  input  logic [TAG_W-1:0]          tag,
  output sacl_pkg::lookup_res_t     res
);

  always_comb begin
    logic                           any_hit;
    logic [sacl_pkg::WAY_IDX_W-1:0] hit_way;
    logic [sacl_pkg::WAY_IDX_W-1:0] free_way;
    any_hit  = 1'b0;
    hit_way  = '0;
    free_way = '0;
    // Walk downward so the lowest-numbered way wins.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (row_tags[w*TAG_W +: TAG_W] == tag)) begin
        any_hit = 1'b1;
        hit_way = sacl_pkg::WAY_IDX_W'(w);
      end
      if (!row_valid[w]) begin
        free_way = sacl_pkg::WAY_IDX_W'(w);
      end
    end
    res.hit   = any_hit;
    res.flush = !any_hit && (&row_valid);
    res.way   = any_hit ? hit_way : (res.flush ? '0 : free_way);
  end

endmodule

@@ tb/tb.sv @@
// Testbench for set_assoc_cache_tag_lookup_unit: directed and random address traffic
// with a self-checking scoreboard. Depends on sacl_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int SETS = 128;
  localparam int WAYS = 4;

  // One lookup result as seen on the output channel.
  typedef struct {
    logic        hit;
    logic [1:0]  way;
    logic        set_flushed;
    logic [6:0]  set_index;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] access_total;
  } lookup_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [sacl_pkg::OFS_W-1:0] cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [31:0]                address;
  logic                       out_valid;
  logic                       out_stall;
  logic                       hit;
  logic [1:0]                 way;
  logic                       set_flushed;
  logic [6:0]                 set_index;
  logic [31:0]                hit_total;
  logic [31:0]                miss_total;
  logic [31:0]                access_total;

  // Shadow copy of the tag store, counters and offset register.
  bit                         line_valid [WAYS][SETS];
  logic [22:0]                line_tag   [WAYS][SETS];
  logic [31:0]                hits_seen;
  logic [31:0]                misses_seen;
  logic [31:0]                accesses_seen;
  logic [sacl_pkg::OFS_W-1:0] offset_bits;

  lookup_result_t   expected_lookups [$];
  logic [31:0]      recent_addresses [$];
  int               mismatch_count;
  bit               steady_flow;   // when set, neither side idles

  set_assoc_cache_tag_lookup_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .address      (address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .way          (way),
    .set_flushed  (set_flushed),
    .set_index    (set_index),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .access_total (access_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~2k items).
  initial begin
    #3_000_000;
    $display("set_assoc_cache_tag_lookup_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Offset register values outside the legal range are clamped by the block.
  function automatic logic [sacl_pkg::OFS_W-1:0] effective_offset();
    if (offset_bits < sacl_pkg::OFS_MIN) return sacl_pkg::OFS_MIN;
    if (offset_bits > sacl_pkg::OFS_MAX) return sacl_pkg::OFS_MAX;
    return offset_bits;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Looks one address up in the shadow store, updates it, returns the result.
  function automatic lookup_result_t predict_lookup(logic [31:0] addr);
    logic [31:0]    blk;
    logic [6:0]     set_no;
    logic [22:0]    tag;
    bit             done;
    lookup_result_t r;
    blk    = addr >> effective_offset();
    set_no = blk[6:0];
    tag    = blk[29:7];   // offset is at least 2, so bits 31:30 are zero
    r.hit  = 1'b0;
    r.way  = 2'd0;
    r.set_flushed = 1'b0;
    accesses_seen = bump(accesses_seen);
    for (int w = 0; w < WAYS; w++) begin
      if (!r.hit && line_valid[w][set_no] && line_tag[w][set_no] == tag) begin
        r.hit = 1'b1;
        r.way = w[1:0];
      end
    end
    if (r.hit) begin
      hits_seen = bump(hits_seen);
    end else begin
      misses_seen = bump(misses_seen);
      done = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!done && !line_valid[w][set_no]) begin
          line_valid[w][set_no] = 1'b1;
          line_tag[w][set_no]   = tag;
          r.way = w[1:0];
          done  = 1'b1;
        end
      end
      // Full set: drop every way, refill way 0.
      if (!done) begin
        for (int w = 0; w < WAYS; w++) line_valid[w][set_no] = 1'b0;
        line_valid[0][set_no] = 1'b1;
        line_tag[0][set_no]   = tag;
        r.way = 2'd0;
        r.set_flushed = 1'b1;
      end
    end
    r.set_index    = set_no;
    r.hit_total    = hits_seen;
    r.miss_total   = misses_seen;
    r.access_total = accesses_seen;
    return r;
  endfunction

  // Builds an address for a given tag and set under the current offset.
  function automatic logic [31:0] make_address(logic [22:0] tag, logic [6:0] set_no,
                                               logic [31:0] byte_sel);
    logic [31:0] ofs_mask;
    ofs_mask = (32'd1 << effective_offset()) - 32'd1;
    return ({2'b00, tag, set_no} << effective_offset()) | (byte_sel & ofs_mask);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Every result transfer is matched against the oldest pending lookup.
  always @(posedge clk) begin
    lookup_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: result transfer, expected none, actual hit %0b way %0d set %0d",
                 $time, hit, way, set_index);
        mismatch_count++;
      end else begin
        e = expected_lookups.pop_front();
        check_field("hit",          32'(e.hit),         32'(hit));
        check_field("way",          32'(e.way),         32'(way));
        check_field("set_flushed",  32'(e.set_flushed), 32'(set_flushed));
        check_field("set_index",    32'(e.set_index),   32'(set_index));
        check_field("hit_total",    e.hit_total,        hit_total);
        check_field("miss_total",   e.miss_total,       miss_total);
        check_field("access_total", e.access_total,     access_total);
      end
    end
  end

  // Receiver back-pressure: random stall about 16% of cycles.
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < 16);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One request transfer; valid stays high on return so back-to-back items
  // are sent without dropping valid. Prediction happens at the accepting clock edge.
  task automatic send_address(input logic [31:0] a);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    do @(posedge clk); while (in_stall);
    expected_lookups.push_back(predict_lookup(a));
  endtask

  // Stop sending and wait for every pending result, plus the pipeline depth.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offset register write, only with the block idle.
  task automatic write_offset(input logic [sacl_pkg::OFS_W-1:0] v);
    wait_until_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    offset_bits = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset offset of 6, address extremes, hits within the same block.
  task automatic test_reset_state();
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFC0);   // same block as all-ones
    send_address(32'h0000_003F);   // same block as zero
  endtask

  // Fill all four ways of one set, hit inside it, then overflow it.
  task automatic test_way_fill_and_flush();
    for (int t = 1; t <= 4; t++) send_address(make_address(23'(t), 7'd37, 32'h15));
    send_address(make_address(23'd3, 7'd37, 32'h0));   // hit in way 2
    send_address(make_address(23'd4, 7'd37, 32'h3F));  // hit in way 3
    send_address(make_address(23'd5, 7'd37, 32'h0));   // full set: flush, way 0
    send_address(make_address(23'd5, 7'd37, 32'h1));   // hit in way 0
    send_address(make_address(23'd1, 7'd37, 32'h0));   // refill way 1
  endtask

  // Offset values below and above the legal range are clamped.
  task automatic test_offset_clamp();
    write_offset(4'd0);
    send_address(32'h0000_0004);
    send_address(32'h0000_0007);   // same 4-byte block
    write_offset(4'd15);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_F000);   // same 4 KiB block
    write_offset(4'd1);
    send_address(32'h8000_0002);
    write_offset(4'd13);
    send_address(32'h7FFF_FFFF);
    write_offset(sacl_pkg::OFS_MAX);
    send_address(32'hFFFF_FFFF);
    write_offset(sacl_pkg::OFS_MIN);
    send_address(32'hAAAA_AAAB);
  endtask

  // One phase of random traffic: mostly replays and small tags, in few sets
  // if few_sets, so hits, fills and flushes all happen; the rest is uniform noise.
  task automatic random_phase(int n_items, logic [sacl_pkg::OFS_W-1:0] ofs, bit few_sets,
                              bit pause_midway);
    int          pick;
    logic [31:0] a;
    logic [6:0]  set_no;
    write_offset(ofs);
    for (int i = 0; i < n_items; i++) begin
      // sender holds off until the block is empty, then resumes
      if (pause_midway && i == n_items / 2) wait_until_drained();
      pick = $urandom_range(99);
      set_no = few_sets ? 7'($urandom_range(3)) : 7'($urandom_range(SETS - 1));
      if (pick < 35 && recent_addresses.size() != 0)
        a = recent_addresses[$urandom_range(recent_addresses.size() - 1)];
      else if (pick < 85)
        a = make_address(23'($urandom_range(5)), set_no, $urandom);
      else
        a = $urandom;
      recent_addresses.push_back(a);
      if (recent_addresses.size() > 16) void'(recent_addresses.pop_front());
      send_address(a);
    end
  endtask

  task automatic test_random_traffic();
    random_phase(140, sacl_pkg::OFS_MIN, 1'b1, 1'b0);
    random_phase(140, sacl_pkg::OFS_MAX, 1'b1, 1'b1);
    random_phase(140, 4'd0, 1'b0, 1'b0);
    random_phase(140, 4'd15, 1'b1, 1'b0);
    // long stretch with no idling on either side
    steady_flow = 1'b1;
    random_phase(140, 4'd6, 1'b1, 1'b0);
    steady_flow = 1'b0;
    for (int p = 0; p < 7; p++)
      random_phase(140, 4'($urandom_range(15)), $urandom_range(2) != 0, p == 3);
  endtask

  initial begin
    for (int w = 0; w < WAYS; w++) begin
      for (int s = 0; s < SETS; s++) begin
        line_valid[w][s] = 1'b0;
        line_tag[w][s]   = '0;
      end
    end
    hits_seen      = '0;
    misses_seen    = '0;
    accesses_seen  = '0;
    offset_bits    = sacl_pkg::OFS_RESET;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    address        = '0;
    out_stall      = 1'b0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // The block clears its valid bits after reset; the first transfer
    // simply waits on in_stall.
    test_reset_state();
    test_way_fill_and_flush();
    test_offset_clamp();
    test_random_traffic();

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0)
      $display("set_assoc_cache_tag_lookup_unit regression: pass");
    else
      $display("set_assoc_cache_tag_lookup_unit regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sacl_pkg.sv
rtl/core/sacl_way_match.sv
rtl/core/set_assoc_cache_tag_lookup_unit.sv
tb/tb.sv
